@@ sv/abst_pkg.sv @@
`default_nettype none

package abst_pkg;

    localparam int TREE_SLOTS = 63;
    localparam int IDX_W      = (TREE_SLOTS > 1) ? $clog2(TREE_SLOTS) : 1;
    localparam int VAL_W      = 8;
    localparam int SLOT_W     = 6;
    localparam int SUM_W      = 15;

    localparam logic [VAL_W-1:0] EMPTY_MARK = 8'd32;
    localparam logic [SUM_W-1:0] SUM_MAX    = 15'd32767;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_MIRROR = 2'd1;
    localparam logic [1:0] KIND_SUM    = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VAL_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic              placed;
        logic [SLOT_W-1:0] slot;
        logic [SUM_W-1:0]  weighted_sum;
    } rsp_item_t;

    // mirror position of a slot within its level: flip the bits below the level bit
    function automatic logic [IDX_W:0] mirror_idx(input logic [IDX_W-1:0] i);
        logic [IDX_W:0] j;
        logic [IDX_W:0] w;
        j = {1'b0, i} + (IDX_W+1)'(1);
        w = '0;
        for (int b = 0; b <= IDX_W; b++) begin
            if (j[b]) begin
                w = (IDX_W+1)'(1) << b;
            end
        end
        return (j ^ (w - (IDX_W+1)'(1))) - (IDX_W+1)'(1);
    endfunction

endpackage

`default_nettype wire

@@ sv/abst_ram.sv @@
`default_nettype none

module abst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/array_bst_insert_mirror_sum.sv @@
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | req_item_t  (kind, value)
// rsp     | out       | rsp_valid/rsp_stall | rsp_item_t  (placed, slot, weighted_sum)
// Insert: one RAM read per level walked, then S_DONE. Unused kind: all-zero result.
// Mirror and sum: one slot read per cycle over all TREE_SLOTS slots.
// One item at a time; req_stall is high while an item is at work.
// Reset clears the per-slot valid bits at once (invalid slots read as empty); no sweep.
// The next item is taken while a result still waits in the output register.
`default_nettype none

module array_bst_insert_mirror_sum
    import abst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_item_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_item_t      rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_STREAM,
        S_DONE
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TREE_SLOTS - 1);
    localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W+1)'(TREE_SLOTS);

    state_t                  state_reg, state_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    bank_reg, bank_next;
    logic [TREE_SLOTS-1:0]   valid_reg, valid_next;
    logic                    issue_reg, issue_next;
    logic                    pend_reg, pend_next;
    logic                    rvld_reg, rvld_next;

    rsp_item_t               rsp_reg, rsp_next;
    rsp_item_t               res_reg, res_next;
    logic [1:0]              kind_reg, kind_next;
    logic [VAL_W-1:0]        value_reg, value_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic [IDX_W-1:0]        pidx_reg, pidx_next;
    logic [TREE_SLOTS-1:0]   reach_reg, reach_next;
    logic [TREE_SLOTS-1:0]   wvalid_reg, wvalid_next;

    logic [IDX_W-1:0]        raddr;
    logic                    we0, we1;
    logic [IDX_W-1:0]        waddr;
    logic [VAL_W-1:0]        wdata;
    logic [VAL_W-1:0]        rdata0, rdata1;
    logic [VAL_W-1:0]        d_eff;

    logic [IDX_W:0]          child;
    logic [IDX_W:0]          mirr;
    logic                    par_ok;
    logic                    reach_now;
    logic [VAL_W:0]          add_val;
    logic [SUM_W:0]          sum_tmp;

    abst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TREE_SLOTS)
    ) u_ram0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata0)
    );

    abst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TREE_SLOTS)
    ) u_ram1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata1)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign raddr     = (state_reg == S_INS_RD) ? idx_reg : cnt_reg;
    assign rvld_next = valid_reg[raddr];
    assign d_eff     = rvld_reg ? (bank_reg ? rdata1 : rdata0) : EMPTY_MARK;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        bank_next      = bank_reg;
        valid_next     = valid_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        res_next       = res_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        pidx_next      = pidx_reg;
        reach_next     = reach_reg;
        wvalid_next    = wvalid_reg;
        we0            = 1'b0;
        we1            = 1'b0;
        waddr          = idx_reg;
        wdata          = value_reg;
        child          = {idx_reg, 1'b0} + ((value_reg < d_eff) ? (IDX_W+1)'(1)
                                                                 : (IDX_W+1)'(2));
        mirr           = mirror_idx(pidx_reg);
        par_ok         = (pidx_reg == '0) || reach_reg[(pidx_reg - IDX_W'(1)) >> 1];
        reach_now      = (d_eff != EMPTY_MARK) && par_ok;
        add_val        = pidx_reg[0] ? {d_eff, 1'b0} : {1'b0, d_eff};
        sum_tmp        = {1'b0, res_reg.weighted_sum} + (SUM_W+1)'(add_val);

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next   = req.kind;
                    value_next  = req.value;
                    res_next    = '0;
                    idx_next    = '0;
                    cnt_next    = '0;
                    issue_next  = 1'b1;
                    pend_next   = 1'b0;
                    wvalid_next = '0;
                    unique case (req.kind) inside
                        KIND_INSERT:         state_next = S_INS_RD;
                        KIND_MIRROR, KIND_SUM: state_next = S_STREAM;
                        default:             state_next = S_DONE;
                    endcase
                end
            end

            S_INS_RD:
            begin
                state_next = S_INS_CHK;
            end

            S_INS_CHK:
            begin
                if (d_eff == EMPTY_MARK)
                begin
                    we0                 = !bank_reg;
                    we1                 = bank_reg;
                    valid_next[idx_reg] = 1'b1;
                    res_next.placed     = 1'b1;
                    res_next.slot       = SLOT_W'({{SLOT_W{1'b0}}, idx_reg});
                    state_next          = S_DONE;
                end
                else if (child >= SLOTS_EXT)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = child[IDX_W-1:0];
                    state_next = S_INS_RD;
                end
            end

            S_STREAM:
            begin
                if (issue_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = cnt_reg;
                    if (cnt_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (kind_reg == KIND_MIRROR)
                    begin
                        reach_next[pidx_reg] = reach_now;
                        if (reach_now && (mirr < SLOTS_EXT))
                        begin
                            we0                           = bank_reg;
                            we1                           = !bank_reg;
                            waddr                         = mirr[IDX_W-1:0];
                            wdata                         = d_eff;
                            wvalid_next[mirr[IDX_W-1:0]]  = 1'b1;
                        end
                    end
                    else if (d_eff != EMPTY_MARK)
                    begin
                        res_next.weighted_sum = (sum_tmp > {1'b0, SUM_MAX}) ? SUM_MAX
                                                                           : sum_tmp[SUM_W-1:0];
                    end
                    if (!issue_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    if (kind_reg == KIND_MIRROR)
                    begin
                        bank_next  = !bank_reg;
                        valid_next = wvalid_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            bank_reg      <= 1'b0;
            valid_reg     <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            rvld_reg      <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            bank_reg      <= bank_next;
            valid_reg     <= valid_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            rvld_reg      <= rvld_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        pidx_reg   <= pidx_next;
        reach_reg  <= reach_next;
        wvalid_reg <= wvalid_next;
    end

endmodule

`default_nettype wire

@@ sv/abst_checker.sv @@
`default_nettype none

module abst_checker
    import abst_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      req_valid,
    input wire logic      req_stall,
    input wire req_item_t req,
    input wire logic      rsp_valid,
    input wire logic      rsp_stall,
    input wire rsp_item_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("rsp item changed or dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("new item taken while previous item at work");

    a_insert_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.placed |-> rsp.weighted_sum == '0)
        else $error("insert result carries a sum");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.placed |-> rsp.slot == '0)
        else $error("slot set without a placement");

    a_kind_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid && req.kind != KIND_INSERT
        && req.kind != KIND_MIRROR && req.kind != KIND_SUM |=> ##1 rsp_valid && rsp == '0)
        else $error("unused kind gave a nonzero result");

endmodule

bind array_bst_insert_mirror_sum abst_checker u_abst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
